@@ design/mbad_pkg.sv @@
// Shared constants, types and helper functions of the multilook box average decimator.
package mbad_pkg;

    // Field and state widths
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 40;
    localparam int MAX_COLS   = 4096;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int OCOL_W     = COL_W + 1;
    localparam int LINE_W     = 13;
    localparam int OFS_W      = 12;
    localparam int MAX_FACTOR = 16;
    localparam int FACT_W     = 5;
    localparam int PHASE_W    = 8;
    localparam int PERIOD_W   = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared divider geometry
    localparam int DIV_W     = SUM_W;
    localparam int DVSR_W    = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKS_ROWS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKS_COLS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE_ROWS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE_COLS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NONFINITE_FILL = 3'd7;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [FACT_W-1:0] eff_factor(input logic [FACT_W-1:0] v);
        logic [FACT_W-1:0] r;
        if (v == '0) begin
            r = FACT_W'(1);
        end else if (v > FACT_W'(MAX_FACTOR)) begin
            r = FACT_W'(MAX_FACTOR);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [LINE_W-1:0] eff_width(input logic [LINE_W-1:0] v);
        logic [LINE_W-1:0] r;
        if (v == '0) begin
            r = LINE_W'(1);
        end else if (v > LINE_W'(MAX_COLS)) begin
            r = LINE_W'(MAX_COLS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ design/mbad_col_ram.sv @@
// Single-port-write, single-port-read column sum memory with registered read data.
module mbad_col_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/mbad_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle, shared by all divisions.
module mbad_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbad_pkg::div_req_t div_req,
    output mbad_pkg::div_rsp_t div_rsp
);
    import mbad_pkg::*;

    logic [DIV_W-1:0]     quo_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DVSR_W:0]   r_wide;
    logic [DVSR_W:0]   r_diff;
    logic              r_ge;
    logic [DVSR_W-1:0] rem_next;

    // one restoring step
    always_comb begin
        r_wide   = {rem_reg, quo_reg[DIV_W-1]};
        r_diff   = r_wide - {1'b0, dvsr_reg};
        r_ge     = r_wide >= {1'b0, dvsr_reg};
        rem_next = r_ge ? r_diff[DVSR_W-1:0] : r_wide[DVSR_W-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (div_req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            quo_reg  <= div_req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= div_req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], r_ge};
            rem_reg <= rem_next;
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

@@ design/multilook_box_average_decimator.sv @@
// Top level: counters, sequencer, column sum read-modify-write and output register.
// An item that closes no window only updates the counters; one that closes a window of a
// non-final row also passes the column sum memory read, then write back; one that ends
// a full window then waits for the 40-step shared divider and the output register.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// Reset and every register write start a count computation (one or two divisions) with
// s_tready low. Column sums are not cleared by reset or frame start.
module multilook_box_average_decimator (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic [1:0]  s_tuser,   // [0] not_finite, [1] frame_start
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] average, [43:32] out_column, [47:44] zero
    output logic        m_tlast    // row_end
);
    import mbad_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_CNT_N1  = 3'd0;
    localparam logic [2:0] ST_WAIT_N1 = 3'd1;
    localparam logic [2:0] ST_CNT_N2  = 3'd2;
    localparam logic [2:0] ST_WAIT_N2 = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;
    localparam logic [2:0] ST_SUM     = 3'd5;
    localparam logic [2:0] ST_DIV     = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    // configuration registers
    logic [LINE_W-1:0]     line_width_reg;
    logic [OFS_W-1:0]      row_offset_reg;
    logic [OFS_W-1:0]      col_offset_reg;
    logic [FACT_W-1:0]     looks_rows_reg;
    logic [FACT_W-1:0]     looks_cols_reg;
    logic [FACT_W-1:0]     sub_rows_reg;
    logic [FACT_W-1:0]     sub_cols_reg;
    logic [SAMPLE_W-1:0]   fill_reg;

    // counters and running state
    logic [2:0]            state_reg;
    logic [OFS_W-1:0]      in_row_reg;
    logic [COL_W-1:0]      in_col_reg;
    logic [PHASE_W-1:0]    row_phase_reg;
    logic [PHASE_W-1:0]    col_phase_reg;
    logic [OCOL_W-1:0]     out_col_reg;
    logic signed [SUM_W-1:0] window_sum_reg;
    logic [OCOL_W-1:0]     n1_reg;
    logic [OCOL_W-1:0]     count_reg;

    // request latched while its column sum is read
    logic [COL_W-1:0]      lat_col_reg;
    logic                  lat_first_row_reg;
    logic                  lat_last_row_reg;
    logic                  lat_row_end_reg;
    logic                  neg_reg;

    // output register
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_avg_reg;
    logic [COL_W-1:0]      out_column_reg;
    logic                  out_last_reg;

    // effective configuration
    logic [LINE_W-1:0]     w_eff;
    logic [FACT_W-1:0]     lr_eff;
    logic [FACT_W-1:0]     lc_eff;
    logic [PERIOD_W-1:0]   pr_eff;
    logic [PERIOD_W-1:0]   pc_eff;
    logic [PERIOD_W-1:0]   area;
    logic                  n2_valid;
    logic [LINE_W-1:0]     n2_dividend;

    always_comb begin
        w_eff       = eff_width(line_width_reg);
        lr_eff      = eff_factor(looks_rows_reg);
        lc_eff      = eff_factor(looks_cols_reg);
        pr_eff      = PERIOD_W'(eff_factor(sub_rows_reg) * lr_eff);
        pc_eff      = PERIOD_W'(eff_factor(sub_cols_reg) * lc_eff);
        area        = PERIOD_W'(lr_eff * lc_eff);
        n2_valid    = (w_eff > LINE_W'(col_offset_reg))
                   && ((w_eff - LINE_W'(col_offset_reg)) >= LINE_W'(lc_eff));
        n2_dividend = w_eff - LINE_W'(col_offset_reg) - LINE_W'(lc_eff);
    end

    // per-item window logic
    logic                    accept;
    logic                    fs;
    logic [OFS_W-1:0]        c_row;
    logic [COL_W-1:0]        c_col;
    logic [PHASE_W-1:0]      c_rph;
    logic [PHASE_W-1:0]      c_cph;
    logic [OCOL_W-1:0]       c_ocol;
    logic signed [SUM_W-1:0] c_ws;
    logic signed [SUM_W-1:0] s_ext;
    logic signed [SUM_W-1:0] ws_new;
    logic                    col_active;
    logic                    in_window;
    logic                    close;
    logic                    cph_wrap;
    logic                    line_end;
    logic [PHASE_W-1:0]      cph_next;
    logic [OCOL_W-1:0]       ocol_next;
    logic [COL_W-1:0]        col_next;
    logic [OFS_W-1:0]        row_next;
    logic [PHASE_W-1:0]      rph_next;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        fs     = s_tuser[1];
        c_row  = fs ? '0 : in_row_reg;
        c_col  = fs ? '0 : in_col_reg;
        c_rph  = fs ? '0 : row_phase_reg;
        c_cph  = fs ? '0 : col_phase_reg;
        c_ocol = fs ? '0 : out_col_reg;
        c_ws   = fs ? '0 : window_sum_reg;

        s_ext  = s_tuser[0] ? SUM_W'(signed'(fill_reg)) : SUM_W'(signed'(s_tdata));
        ws_new = (c_cph == '0) ? s_ext : c_ws + s_ext;

        col_active = c_col >= col_offset_reg;
        in_window  = col_active && (c_row >= row_offset_reg)
                  && (c_rph < PHASE_W'(lr_eff)) && (c_cph < PHASE_W'(lc_eff));
        close      = in_window && (c_cph == PHASE_W'(lc_eff) - PHASE_W'(1))
                  && (c_ocol < count_reg);

        // column phase and output column
        cph_next  = c_cph;
        ocol_next = c_ocol;
        cph_wrap  = ({1'b0, c_cph} + PERIOD_W'(1)) >= pc_eff;
        if (col_active) begin
            if (cph_wrap) begin
                cph_next = '0;
                if (c_ocol < OCOL_W'(MAX_COLS)) begin
                    ocol_next = c_ocol + OCOL_W'(1);
                end
            end else begin
                cph_next = c_cph + PHASE_W'(1);
            end
        end

        // line end wraps the column and advances the row, or the row phase once past the row offset
        line_end = ({1'b0, c_col} + LINE_W'(1)) >= w_eff;
        col_next = c_col + COL_W'(1);
        row_next = c_row;
        rph_next = c_rph;
        if (line_end) begin
            col_next  = '0;
            cph_next  = '0;
            ocol_next = '0;
            if (c_row < row_offset_reg) begin
                row_next = c_row + OFS_W'(1);
            end else if (({1'b0, c_rph} + PERIOD_W'(1)) >= pr_eff) begin
                rph_next = '0;
            end else begin
                rph_next = c_rph + PHASE_W'(1);
            end
        end
    end

    // column sum memory
    logic signed [SUM_W-1:0] ram_rd_data;
    logic signed [SUM_W-1:0] total;
    logic [DIV_W-1:0]        total_mag;

    always_comb begin
        total     = lat_first_row_reg ? window_sum_reg : ram_rd_data + window_sum_reg;
        total_mag = total[SUM_W-1] ? DIV_W'(-total) : DIV_W'(total);
    end

    mbad_col_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (SUM_W)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_SUM),
        .wr_addr (lat_col_reg),
        .wr_data (total),
        .rd_en   (accept && close),
        .rd_addr (c_ocol[COL_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // shared divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(w_eff);
        div_req.divisor  = pc_eff;
        unique case (state_reg)
            ST_CNT_N1: begin
                div_req.start = 1'b1;
            end
            ST_CNT_N2: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(n2_dividend);
            end
            ST_SUM: begin
                div_req.start    = lat_last_row_reg;
                div_req.dividend = total_mag;
                div_req.divisor  = area;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    mbad_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // signed average from the divider result
    logic [DIV_W-1:0] quo_signed;
    logic [OCOL_W-1:0] n2_plus1;

    assign quo_signed = neg_reg ? -div_rsp.quotient : div_rsp.quotient;
    assign n2_plus1   = div_rsp.quotient[OCOL_W-1:0] + OCOL_W'(1);

    assign s_tready = (state_reg == ST_IDLE);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_W'(MAX_COLS);
            row_offset_reg <= '0;
            col_offset_reg <= '0;
            looks_rows_reg <= FACT_W'(1);
            looks_cols_reg <= FACT_W'(1);
            sub_rows_reg   <= FACT_W'(1);
            sub_cols_reg   <= FACT_W'(1);
            fill_reg       <= SAMPLE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:     line_width_reg <= cfg_data[LINE_W-1:0];
                CFG_ROW_OFFSET:     row_offset_reg <= cfg_data[OFS_W-1:0];
                CFG_COL_OFFSET:     col_offset_reg <= cfg_data[OFS_W-1:0];
                CFG_LOOKS_ROWS:     looks_rows_reg <= cfg_data[FACT_W-1:0];
                CFG_LOOKS_COLS:     looks_cols_reg <= cfg_data[FACT_W-1:0];
                CFG_SUBSAMPLE_ROWS: sub_rows_reg   <= cfg_data[FACT_W-1:0];
                CFG_SUBSAMPLE_COLS: sub_cols_reg   <= cfg_data[FACT_W-1:0];
                CFG_NONFINITE_FILL: fill_reg       <= cfg_data[SAMPLE_W-1:0];
                default:            fill_reg       <= fill_reg;
            endcase
        end
    end

    // sequencer and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CNT_N1;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            row_phase_reg  <= '0;
            col_phase_reg  <= '0;
            out_col_reg    <= '0;
            window_sum_reg <= '0;
            n1_reg         <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (accept) begin
                in_row_reg    <= row_next;
                in_col_reg    <= col_next;
                row_phase_reg <= rph_next;
                col_phase_reg <= cph_next;
                out_col_reg   <= ocol_next;
                if (in_window) begin
                    window_sum_reg <= ws_new;
                end else begin
                    window_sum_reg <= c_ws;
                end
            end

            if (cfg_wr_en) begin
                state_reg <= ST_CNT_N1;
            end else begin
                unique case (state_reg)
                    ST_CNT_N1: state_reg <= ST_WAIT_N1;
                    ST_WAIT_N1: begin
                        if (div_rsp.done) begin
                            n1_reg <= div_rsp.quotient[OCOL_W-1:0];
                            if (n2_valid) begin
                                state_reg <= ST_CNT_N2;
                            end else begin
                                count_reg <= '0;
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                    ST_CNT_N2: state_reg <= ST_WAIT_N2;
                    ST_WAIT_N2: begin
                        if (div_rsp.done) begin
                            count_reg <= (n1_reg < n2_plus1) ? n1_reg : n2_plus1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (accept && close) begin
                            state_reg <= ST_SUM;
                        end
                    end
                    ST_SUM: begin
                        state_reg <= lat_last_row_reg ? ST_DIV : ST_IDLE;
                    end
                    ST_DIV: begin
                        if (div_rsp.done) begin
                            state_reg <= ST_OUT;
                        end
                    end
                    ST_OUT: begin
                        if (!out_valid_reg || m_tready) begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    // request payload latched at accept, sign at write back, result into output register
    always_ff @(posedge aclk) begin
        if (accept && close) begin
            lat_col_reg       <= c_ocol[COL_W-1:0];
            lat_first_row_reg <= (c_rph == '0);
            lat_last_row_reg  <= (c_rph == PHASE_W'(lr_eff) - PHASE_W'(1));
            lat_row_end_reg   <= ((c_ocol + OCOL_W'(1)) == count_reg);
        end
        if (state_reg == ST_SUM) begin
            neg_reg <= total[SUM_W-1];
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
            out_avg_reg    <= quo_signed[SAMPLE_W-1:0];
            out_column_reg <= lat_col_reg;
            out_last_reg   <= lat_row_end_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_column_reg, out_avg_reg};
    assign m_tlast  = out_last_reg;

endmodule
